// ===== design/ncc_pkg.sv =====
// Shared types and constants for the NCC stereo disparity block.
package ncc_pkg;

    // Input transfer payload: one pixel pair at the next raster position.
    typedef struct packed {
        logic [7:0] left_pixel;
        logic [7:0] right_pixel;
    } t_in;

    // Result transfer payload.
    typedef struct packed {
        logic [5:0] disparity;
        logic [9:0] out_row;
        logic [8:0] out_col;
        logic       frame_last;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       wr_en;
        logic       start;
        logic       rd_en;
        logic       rd_first;
        logic       rd_last;
        logic       cmp_step;
        logic [1:0] cmp_idx;
        logic       cmp_update;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sums_ready;
    } t_dp_stat;

    // Result request from the controller to the output register.
    typedef struct packed {
        logic       emit;
        logic [9:0] out_row;
        logic [8:0] out_col;
        logic       frame_last;
    } t_emit;

    // Register map, indexed by word address.
    localparam logic [1:0] REG_SEARCH_RANGE = 2'd0;
    localparam logic [1:0] REG_WINDOW_SIZE  = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

    // Register reset values.
    localparam logic [5:0]  RST_SEARCH_RANGE = 6'd60;
    localparam logic [3:0]  RST_WINDOW_SIZE  = 4'd4;
    localparam logic [9:0]  RST_IMAGE_WIDTH  = 10'd280;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd223;

endpackage

// ===== design/ncc_stereo_disparity.sv =====
// Top level of the NCC stereo disparity block: register port, output register, assertions.
//
// Pixel pairs enter in raster order on the input channel (i_valid, o_ready, i_data); each
// transfer writes the pair into the line buffers. When a pixel completes a w-by-w window
// clear of the last row and column, one result (o_valid, i_ready, o_data) follows: the best
// disparity for the window's top-left corner, with its row, column and end-of-frame flag.
// Each candidate disparity runs w column reads of all row banks, a four-deep product and
// sum pipeline, four steps of two reused partial-product multipliers for the exact score
// comparison, and an update step. An item with no candidates goes straight to the result
// hand-off, and one without a result is taken without leaving the idle state. The result
// is handed to the output register from the done state and then appears on o_valid.
// One item is worked on at a time; the next input is taken as soon as the result sits in
// the output register, even while the receiver stalls. A finished result waits if the
// output register is still full.
// Reset clears the raster position and loads the register reset values; line buffer
// contents are undefined until written and no clearing pass runs. The user is to
// write the registers over the APB-style port while the block is idle; it is not enforced.
module ncc_stereo_disparity #(
    parameter int MAX_WIDTH     = 512,
    parameter int MAX_HEIGHT    = 1024,
    parameter int MAX_WINDOW    = 8,
    parameter int MAX_DISPARITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ncc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output ncc_pkg::t_out o_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import ncc_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int BW  = $clog2(MAX_WINDOW);
    localparam int WW  = $clog2(MAX_WINDOW + 1);
    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HTW = $clog2(MAX_HEIGHT + 1);
    localparam int KW  = $clog2(MAX_DISPARITY);

    logic [5:0]  r_sr;
    logic [3:0]  r_ws;
    logic [9:0]  r_iw;
    logic [10:0] r_ih;

    logic [WW-1:0]  w_w;
    logic [WDW-1:0] w_wd;
    logic [HTW-1:0] w_ht;

    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    t_emit         w_emit;
    logic [CW-1:0] w_wr_col, w_rd_lcol, w_rd_rcol;
    logic [BW-1:0] w_wr_bank, w_bank_top;
    logic [KW-1:0] w_k, w_best_k;
    logic          w_out_free;

    logic r_out_valid;
    t_out r_out;

    // Register writes complete in the access cycle.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr <= RST_SEARCH_RANGE;
            r_ws <= RST_WINDOW_SIZE;
            r_iw <= RST_IMAGE_WIDTH;
            r_ih <= RST_IMAGE_HEIGHT;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_SEARCH_RANGE: r_sr <= pwdata[5:0];
                REG_WINDOW_SIZE:  r_ws <= pwdata[3:0];
                REG_IMAGE_WIDTH:  r_iw <= pwdata[9:0];
                REG_IMAGE_HEIGHT: r_ih <= pwdata[10:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_SEARCH_RANGE: prdata = 32'(r_sr);
            REG_WINDOW_SIZE:  prdata = 32'(r_ws);
            REG_IMAGE_WIDTH:  prdata = 32'(r_iw);
            REG_IMAGE_HEIGHT: prdata = 32'(r_ih);
            default:          prdata = '0;
        endcase
    end

    // Saturate the geometry registers into the supported ranges.
    assign w_w  = (r_ws == '0) ? WW'(1) :
                  ((32'(r_ws) > MAX_WINDOW) ? WW'(MAX_WINDOW) : WW'(r_ws));
    assign w_wd = (r_iw == '0) ? WDW'(1) :
                  ((32'(r_iw) > MAX_WIDTH) ? WDW'(MAX_WIDTH) : WDW'(r_iw));
    assign w_ht = (r_ih == '0) ? HTW'(1) :
                  ((32'(r_ih) > MAX_HEIGHT) ? HTW'(MAX_HEIGHT) : HTW'(r_ih));

    ncc_ctrl #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .MAX_WINDOW    (MAX_WINDOW),
        .MAX_DISPARITY (MAX_DISPARITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_sr   (r_sr),
        .i_cfg_w    (w_w),
        .i_cfg_wd   (w_wd),
        .i_cfg_ht   (w_ht),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_out_free (w_out_free),
        .o_emit     (w_emit),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat),
        .o_wr_col   (w_wr_col),
        .o_wr_bank  (w_wr_bank),
        .o_rd_lcol  (w_rd_lcol),
        .o_rd_rcol  (w_rd_rcol),
        .o_bank_top (w_bank_top),
        .o_k        (w_k)
    );

    ncc_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_WINDOW    (MAX_WINDOW),
        .MAX_DISPARITY (MAX_DISPARITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_pixels   (i_data),
        .i_wr_col   (w_wr_col),
        .i_wr_bank  (w_wr_bank),
        .i_rd_lcol  (w_rd_lcol),
        .i_rd_rcol  (w_rd_rcol),
        .i_bank_top (w_bank_top),
        .i_cfg_w    (w_w),
        .i_k        (w_k),
        .o_best_k   (w_best_k)
    );

    // Output register: free when empty or when its result transfers this cycle.
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.emit) begin
            r_out.disparity  <= 6'(w_best_k);
            r_out.out_row    <= w_emit.out_row;
            r_out.out_col    <= w_emit.out_col;
            r_out.frame_last <= w_emit.frame_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTH
    // A result is only handed over when the output register can take it.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit.emit |-> (!r_out_valid || i_ready))
        else $error("result handed over while output register is full");

    // A handed-over result is presented in the following cycle.
    a_emit_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit.emit |=> o_valid)
        else $error("result not presented after hand-over");

    // No new pixel is taken while window columns are being read.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_en |-> !o_ready)
        else $error("input ready while scoring");
`endif

endmodule

// ===== design/ncc_datapath.sv =====
// Datapath: line buffers, window correlation sums and exact score comparison.
module ncc_datapath #(
    parameter int MAX_WIDTH     = 512,
    parameter int MAX_WINDOW    = 8,
    parameter int MAX_DISPARITY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ncc_pkg::t_dp_cmd                 i_cmd,
    output ncc_pkg::t_dp_stat                o_stat,
    input  ncc_pkg::t_in                     i_pixels,
    input  logic [$clog2(MAX_WIDTH)-1:0]     i_wr_col,
    input  logic [$clog2(MAX_WINDOW)-1:0]    i_wr_bank,
    input  logic [$clog2(MAX_WIDTH)-1:0]     i_rd_lcol,
    input  logic [$clog2(MAX_WIDTH)-1:0]     i_rd_rcol,
    input  logic [$clog2(MAX_WINDOW)-1:0]    i_bank_top,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]  i_cfg_w,
    input  logic [$clog2(MAX_DISPARITY)-1:0] i_k,
    output logic [$clog2(MAX_DISPARITY)-1:0] o_best_k
);
    import ncc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int BW = $clog2(MAX_WINDOW);
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int KW = $clog2(MAX_DISPARITY);
    localparam int SW = 16 + 2 * $clog2(MAX_WINDOW);
    localparam int NW = 2 * SW;
    localparam int AW = 4 * SW;

    // One bank per buffered row; all left banks share one read column, all right banks another.
    logic [7:0] r_lmem [MAX_WINDOW][MAX_WIDTH];
    logic [7:0] r_rmem [MAX_WINDOW][MAX_WIDTH];
    logic [7:0] r_lrd  [MAX_WINDOW];
    logic [7:0] r_rrd  [MAX_WINDOW];

    logic [15:0] r_plr [MAX_WINDOW];
    logic [15:0] r_pll [MAX_WINDOW];
    logic [15:0] r_prr [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] w_mask;

    logic r_v1, r_f1, r_l1, r_v2, r_f2, r_l2, r_v3, r_v4;
    logic [SW-1:0] r_s1, r_s2, r_s3;
    logic [SW-1:0] w_sum1, w_sum2, w_sum3;
    logic [NW-1:0] r_num, r_den;

    logic [NW-1:0] r_best_num, r_best_den;
    logic [KW-1:0] r_best_k;
    logic          r_have;
    logic [AW-1:0] r_x, r_y;
    logic [SW-1:0] w_ax, w_bx, w_ay, w_by;
    logic [NW-1:0] w_ppx, w_ppy;
    logic [AW-1:0] w_shx, w_shy;
    logic          w_take;

    // Line buffer writes, one pixel pair per accepted transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_lmem[i_wr_bank][i_wr_col] <= i_pixels.left_pixel;
            r_rmem[i_wr_bank][i_wr_col] <= i_pixels.right_pixel;
        end
    end

    // Registered reads of one window column from every bank.
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < MAX_WINDOW; b++) begin
            r_lrd[b] <= r_lmem[b][i_rd_lcol];
            r_rrd[b] <= r_rmem[b][i_rd_rcol];
        end
    end

    // A bank takes part when its row lies among the newest w rows.
    always_comb begin
        logic [BW-1:0] bank_dist;
        for (int b = 0; b < MAX_WINDOW; b++) begin
            bank_dist = i_bank_top - BW'(b);
            if (i_bank_top < BW'(b)) begin
                bank_dist = BW'(i_bank_top + BW'(MAX_WINDOW) - BW'(b));
            end
            w_mask[b] = (WW'(bank_dist) < i_cfg_w);
        end
    end

    // Products of each bank's pixels, masked outside the window.
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < MAX_WINDOW; b++) begin
            r_plr[b] <= w_mask[b] ? r_lrd[b] * r_rrd[b] : 16'd0;
            r_pll[b] <= w_mask[b] ? r_lrd[b] * r_lrd[b] : 16'd0;
            r_prr[b] <= w_mask[b] ? r_rrd[b] * r_rrd[b] : 16'd0;
        end
    end

    // Column sums across the banks.
    always_comb begin
        w_sum1 = '0;
        w_sum2 = '0;
        w_sum3 = '0;
        for (int b = 0; b < MAX_WINDOW; b++) begin
            w_sum1 = w_sum1 + SW'(r_plr[b]);
            w_sum2 = w_sum2 + SW'(r_pll[b]);
            w_sum3 = w_sum3 + SW'(r_prr[b]);
        end
    end

    // Pipeline tags that follow each column read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_f1 <= 1'b0;
            r_l1 <= 1'b0;
            r_v2 <= 1'b0;
            r_f2 <= 1'b0;
            r_l2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_f1 <= i_cmd.rd_first;
            r_l1 <= i_cmd.rd_last;
            r_v2 <= r_v1;
            r_f2 <= r_f1;
            r_l2 <= r_l1;
            r_v3 <= r_v2 & r_l2;
            r_v4 <= r_v3;
        end
    end

    // Window accumulation, then numerator and denominator of the score.
    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_s1 <= (r_f2 ? '0 : r_s1) + w_sum1;
            r_s2 <= (r_f2 ? '0 : r_s2) + w_sum2;
            r_s3 <= (r_f2 ? '0 : r_s3) + w_sum3;
        end
        if (r_v3) begin
            r_num <= r_s1 * r_s1;
            r_den <= r_s2 * r_s3;
        end
    end

    assign o_stat.sums_ready = r_v4;

    // Cross products num*best_den and best_num*den, one partial product of each a step.
    always_comb begin
        w_ax  = i_cmd.cmp_idx[1] ? r_num[NW-1:SW]      : r_num[SW-1:0];
        w_bx  = i_cmd.cmp_idx[0] ? r_best_den[NW-1:SW] : r_best_den[SW-1:0];
        w_ay  = i_cmd.cmp_idx[1] ? r_best_num[NW-1:SW] : r_best_num[SW-1:0];
        w_by  = i_cmd.cmp_idx[0] ? r_den[NW-1:SW]      : r_den[SW-1:0];
        w_ppx = w_ax * w_bx;
        w_ppy = w_ay * w_by;
        case (i_cmd.cmp_idx)
            2'd0: begin
                w_shx = AW'(w_ppx);
                w_shy = AW'(w_ppy);
            end
            2'd3: begin
                w_shx = AW'(w_ppx) << NW;
                w_shy = AW'(w_ppy) << NW;
            end
            default: begin
                w_shx = AW'(w_ppx) << SW;
                w_shy = AW'(w_ppy) << SW;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_step) begin
            r_x <= ((i_cmd.cmp_idx == 2'd0) ? '0 : r_x) + w_shx;
            r_y <= ((i_cmd.cmp_idx == 2'd0) ? '0 : r_y) + w_shy;
        end
    end

    // A candidate with a zero term never wins; the first one with a score does.
    assign w_take = (r_num != '0) && (r_den != '0) && (!r_have || (r_x > r_y));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_best_k   <= '0;
            r_best_num <= '0;
            r_best_den <= NW'(1);
        end else if (i_cmd.start) begin
            r_have     <= 1'b0;
            r_best_k   <= '0;
            r_best_num <= '0;
            r_best_den <= NW'(1);
        end else if (i_cmd.cmp_update && w_take) begin
            r_have     <= 1'b1;
            r_best_k   <= i_k;
            r_best_num <= r_num;
            r_best_den <= r_den;
        end
    end

    assign o_best_k = r_best_k;

endmodule

// ===== design/ncc_ctrl.sv =====
// Controller: raster position, candidate and column sequencing, result hand-off.
module ncc_ctrl #(
    parameter int MAX_WIDTH     = 512,
    parameter int MAX_HEIGHT    = 1024,
    parameter int MAX_WINDOW    = 8,
    parameter int MAX_DISPARITY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [5:0]                       i_cfg_sr,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]  i_cfg_w,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   i_cfg_wd,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]  i_cfg_ht,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_out_free,
    output ncc_pkg::t_emit                   o_emit,
    output ncc_pkg::t_dp_cmd                 o_cmd,
    input  ncc_pkg::t_dp_stat                i_stat,
    output logic [$clog2(MAX_WIDTH)-1:0]     o_wr_col,
    output logic [$clog2(MAX_WINDOW)-1:0]    o_wr_bank,
    output logic [$clog2(MAX_WIDTH)-1:0]     o_rd_lcol,
    output logic [$clog2(MAX_WIDTH)-1:0]     o_rd_rcol,
    output logic [$clog2(MAX_WINDOW)-1:0]    o_bank_top,
    output logic [$clog2(MAX_DISPARITY)-1:0] o_k
);
    import ncc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int BW = $clog2(MAX_WINDOW);
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int KW = $clog2(MAX_DISPARITY);
    localparam int XW = CW + 1;
    localparam int YW = RW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_MUL,
        S_UPD,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [BW-1:0] r_bank, n_bank;
    logic [9:0]    r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic          r_last, n_last;
    logic [BW-1:0] r_bank_top, n_bank_top;
    logic [KW-1:0] r_kmax, n_kmax;
    logic [KW-1:0] r_k, n_k;
    logic [BW-1:0] r_jj, n_jj;
    logic [1:0]    r_p, n_p;

    logic [CW-1:0] p_col;
    logic [YW-1:0] t_row;
    logic [RW-1:0] p_row;
    logic [BW-1:0] p_bank, inc_bank, inc_pbank;
    logic [YW-1:0] r1;
    logic [XW-1:0] c1;
    logic          due, score, last_pos;
    logic [YW-1:0] pos_i;
    logic [CW-1:0] pos_j, jmw;
    logic [KW-1:0] kmax;
    logic [CW-1:0] x_col;
    logic [RW-1:0] x_row;
    logic [BW-1:0] x_bank;
    logic          jj_last;

    // Bank increments wrap at the number of buffered rows.
    assign inc_bank  = (r_bank == BW'(MAX_WINDOW - 1)) ? '0 : r_bank + BW'(1);

    // Position of the arriving pixel, after any wrap caused by a new size.
    always_comb begin
        p_col  = r_col;
        t_row  = YW'(r_row);
        p_bank = r_bank;
        if (r_col >= i_cfg_wd) begin
            p_col  = '0;
            t_row  = YW'(r_row) + YW'(1);
            p_bank = inc_bank;
        end
        p_row = t_row[RW-1:0];
        if (t_row >= i_cfg_ht) begin
            p_row  = '0;
            p_bank = '0;
        end
    end

    assign inc_pbank = (p_bank == BW'(MAX_WINDOW - 1)) ? '0 : p_bank + BW'(1);

    // Window placement and the candidate range for this pixel.
    always_comb begin
        r1       = YW'(p_row) + YW'(1);
        c1       = XW'(p_col) + XW'(1);
        due      = (r1 >= i_cfg_w) && (c1 >= i_cfg_w) && (r1 < i_cfg_ht) && (c1 < i_cfg_wd);
        pos_i    = r1 - YW'(i_cfg_w);
        pos_j    = CW'(c1 - XW'(i_cfg_w));
        score    = (pos_j >= i_cfg_w);
        jmw      = pos_j - CW'(i_cfg_w);
        last_pos = ((YW'(p_row) + YW'(2)) == i_cfg_ht) && ((c1 + XW'(1)) == i_cfg_wd);
        if ((32'(jmw) <= 32'(i_cfg_sr)) && (32'(jmw) <= MAX_DISPARITY - 1)) begin
            kmax = KW'(jmw);
        end else if (32'(i_cfg_sr) <= MAX_DISPARITY - 1) begin
            kmax = KW'(i_cfg_sr);
        end else begin
            kmax = KW'(MAX_DISPARITY - 1);
        end
    end

    // Raster position after this pixel.
    always_comb begin
        x_col  = c1[CW-1:0];
        x_row  = p_row;
        x_bank = p_bank;
        if (c1 >= i_cfg_wd) begin
            x_col  = '0;
            x_row  = r1[RW-1:0];
            x_bank = inc_pbank;
            if (r1 >= i_cfg_ht) begin
                x_row  = '0;
                x_bank = '0;
            end
        end
    end

    assign jj_last = ((WW'(r_jj) + WW'(1)) == i_cfg_w);

    // Next-state logic.
    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_bank     = r_bank;
        n_i        = r_i;
        n_j        = r_j;
        n_last     = r_last;
        n_bank_top = r_bank_top;
        n_kmax     = r_kmax;
        n_k        = r_k;
        n_jj       = r_jj;
        n_p        = r_p;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_col  = x_col;
                    n_row  = x_row;
                    n_bank = x_bank;
                    if (due) begin
                        n_i        = 10'(pos_i);
                        n_j        = pos_j;
                        n_last     = last_pos;
                        n_bank_top = p_bank;
                        n_kmax     = kmax;
                        n_k        = '0;
                        n_jj       = '0;
                        n_state    = score ? S_READ : S_DONE;
                    end
                end
            end
            S_READ: begin
                n_jj = r_jj + BW'(1);
                if (jj_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_stat.sums_ready) begin
                    n_p     = 2'd0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_p = r_p + 2'd1;
                if (r_p == 2'd3) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_k == r_kmax) begin
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k + KW'(1);
                    n_jj    = '0;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_col      <= '0;
            r_row      <= '0;
            r_bank     <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_last     <= 1'b0;
            r_bank_top <= '0;
            r_kmax     <= '0;
            r_k        <= '0;
            r_jj       <= '0;
            r_p        <= '0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_bank     <= n_bank;
            r_i        <= n_i;
            r_j        <= n_j;
            r_last     <= n_last;
            r_bank_top <= n_bank_top;
            r_kmax     <= n_kmax;
            r_k        <= n_k;
            r_jj       <= n_jj;
            r_p        <= n_p;
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd            = '0;
        o_cmd.wr_en      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.start      = (r_state == S_IDLE) && i_in_valid && due;
        o_cmd.rd_en      = (r_state == S_READ);
        o_cmd.rd_first   = (r_state == S_READ) && (r_jj == '0);
        o_cmd.rd_last    = (r_state == S_READ) && jj_last;
        o_cmd.cmp_step   = (r_state == S_MUL);
        o_cmd.cmp_idx    = r_p;
        o_cmd.cmp_update = (r_state == S_UPD);
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_wr_col   = p_col;
    assign o_wr_bank  = p_bank;
    assign o_rd_lcol  = r_j + CW'(r_jj);
    assign o_rd_rcol  = r_j - CW'(r_k) + CW'(r_jj);
    assign o_bank_top = r_bank_top;
    assign o_k        = r_k;

    // Result hand-off to the output register.
    always_comb begin
        o_emit.emit       = (r_state == S_DONE) && i_out_free;
        o_emit.out_row    = r_i;
        o_emit.out_col    = 9'(r_j);
        o_emit.frame_last = r_last;
    end

endmodule

// ===== verif/ncc_checker.sv =====
// Checker for the NCC stereo disparity block: predicts every result and compares it.
`timescale 1ns / 100ps

module ncc_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          o_ready,
    input  ncc_pkg::t_in  i_data,
    input  logic          o_valid,
    input  logic          i_ready,
    input  ncc_pkg::t_out o_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    input  logic          pready,
    output int            fail_count,
    output int            pending
);
    import ncc_pkg::*;

    localparam int unsigned LIM_WIDTH  = 512;
    localparam int unsigned LIM_HEIGHT = 1024;
    localparam int unsigned LIM_WINDOW = 8;
    localparam int unsigned LIM_DISP   = 64;

    // Line buffers of both images, slot (row mod 8, column).
    logic [7:0]  left_rows  [0:4095];
    logic [7:0]  right_rows [0:4095];
    int unsigned col_pos;
    int unsigned row_pos;

    // Register copies.
    logic [5:0]  search_reg;
    logic [3:0]  window_reg;
    logic [9:0]  width_reg;
    logic [10:0] height_reg;

    // Disparities still owed by the block, oldest first.
    t_out        owed_disp[$];

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                                int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int unsigned buf_slot(int unsigned row, int unsigned col);
        return (row % LIM_WINDOW) * LIM_WIDTH + (col % LIM_WIDTH);
    endfunction

    // Best disparity for the window with top-left corner (i, j).
    function automatic logic [5:0] best_disparity(int unsigned i, int unsigned j,
                                                  int unsigned w);
        longint unsigned sum_lr, sum_ll, sum_rr, num, den, best_num, best_den;
        logic [127:0]    lhs, rhs;
        logic [7:0]      lv, rv;
        int unsigned     kmax, best;
        bit              have;
        best = 0;
        have = 0;
        best_num = 0;
        best_den = 1;
        if (j < w) return 6'd0;
        kmax = j - w;
        if (kmax > search_reg) kmax = search_reg;
        if (kmax > LIM_DISP - 1) kmax = LIM_DISP - 1;
        for (int unsigned k = 0; k <= kmax; k++) begin
            sum_lr = 0;
            sum_ll = 0;
            sum_rr = 0;
            for (int unsigned ii = 0; ii < w; ii++) begin
                for (int unsigned jj = 0; jj < w; jj++) begin
                    lv = left_rows[buf_slot(i + ii, j + jj)];
                    rv = right_rows[buf_slot(i + ii, j - k + jj)];
                    sum_lr += lv * rv;
                    sum_ll += lv * lv;
                    sum_rr += rv * rv;
                end
            end
            num = sum_lr * sum_lr;
            den = sum_ll * sum_rr;
            if (den == 0 || num == 0) continue;
            lhs = 128'(num) * 128'(best_den);
            rhs = 128'(best_num) * 128'(den);
            if (!have || lhs > rhs) begin
                have = 1;
                best = k;
                best_num = num;
                best_den = den;
            end
        end
        return 6'(best);
    endfunction

    // Store one pixel pair and work out the result it completes, if any.
    task automatic take_pixel(t_in px);
        int unsigned w, wd, ht, r, c, i, j;
        t_out        res;
        w  = clamp_range(window_reg, 1, LIM_WINDOW);
        wd = clamp_range(width_reg, 1, LIM_WIDTH);
        ht = clamp_range(height_reg, 1, LIM_HEIGHT);
        if (col_pos >= wd) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= ht) row_pos = 0;
        r = row_pos;
        c = col_pos;
        left_rows[buf_slot(r, c)]  = px.left_pixel;
        right_rows[buf_slot(r, c)] = px.right_pixel;
        if (r + 1 >= w && c + 1 >= w && r + 1 < ht && c + 1 < wd) begin
            i = r + 1 - w;
            j = c + 1 - w;
            res.disparity  = best_disparity(i, j, w);
            res.out_row    = 10'(i);
            res.out_col    = 9'(j);
            res.frame_last = (i + w + 1 == ht && j + w + 1 == wd);
            owed_disp.push_back(res);
        end
        col_pos++;
        if (col_pos >= wd) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= ht) row_pos = 0;
        end
    endtask

    // Watch register writes, input transfers and result transfers.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            col_pos    = 0;
            row_pos    = 0;
            search_reg = RST_SEARCH_RANGE;
            window_reg = RST_WINDOW_SIZE;
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            owed_disp.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SEARCH_RANGE: search_reg = pwdata[5:0];
                    REG_WINDOW_SIZE:  window_reg = pwdata[3:0];
                    REG_IMAGE_WIDTH:  width_reg  = pwdata[9:0];
                    REG_IMAGE_HEIGHT: height_reg = pwdata[10:0];
                    default: ;
                endcase
            end
            // Results are checked before the new pixel adds its own expectation.
            if (o_valid && i_ready) begin
                if (owed_disp.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, o_data);
                    fail_count++;
                end else begin
                    want = owed_disp.pop_front();
                    if (o_data.disparity !== want.disparity) begin
                        $display("%0t: disparity mismatch, expected %0d, actual %0d",
                                 $time, want.disparity, o_data.disparity);
                        fail_count++;
                    end
                    if (o_data.out_row !== want.out_row) begin
                        $display("%0t: out_row mismatch, expected %0d, actual %0d",
                                 $time, want.out_row, o_data.out_row);
                        fail_count++;
                    end
                    if (o_data.out_col !== want.out_col) begin
                        $display("%0t: out_col mismatch, expected %0d, actual %0d",
                                 $time, want.out_col, o_data.out_col);
                        fail_count++;
                    end
                    if (o_data.frame_last !== want.frame_last) begin
                        $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                                 $time, want.frame_last, o_data.frame_last);
                        fail_count++;
                    end
                end
            end
            if (i_valid && o_ready) take_pixel(i_data);
        end
        pending = owed_disp.size();
    end

    initial begin
        fail_count = 0;
        pending    = 0;
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the NCC stereo disparity block: stimulus, register setup and verdict.
`timescale 1ns / 100ps

module tb;
    import ncc_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int SETTLE      = 1200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          pixels_sent;
    int          cycles;
    bit          quiet;

    // Raster position and frame size as the block will see them.
    int unsigned pos_r;
    int unsigned pos_c;
    int unsigned frame_w;
    int unsigned frame_h;
    logic [7:0]  left_img [0:16383];

    ncc_stereo_disparity DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ncc_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("ncc_stereo_disparity regression: fail");
                $finish;
            end
        end
    end

    // Receiver: short random stalls, and one long hold-off so the block backs up.
    initial begin
        bit held;
        held    = 0;
        i_ready = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && pixels_sent >= 400) begin
                held = 1;
                i_ready <= 1'b0;
                repeat (500) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                                int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Let all owed results drain, then allow for a last item still being scored.
    task automatic wait_idle();
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // New settings; the raster position wraps as the block will wrap it.
    task automatic configure(int unsigned search, int unsigned win, int unsigned width,
                             int unsigned height);
        i_valid <= 1'b0;
        wait_idle();
        write_reg(REG_SEARCH_RANGE, search);
        write_reg(REG_WINDOW_SIZE, win);
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        frame_w = clamp_range(width, 1, 512);
        frame_h = clamp_range(height, 1, 1024);
        if (pos_c >= frame_w) begin
            pos_c = 0;
            pos_r++;
        end
        if (pos_r >= frame_h) pos_r = 0;
    endtask

    // One input transfer, with an occasional gap in front of it.
    task automatic send_pixel(logic [7:0] lp, logic [7:0] rp);
        if (pixels_sent >= 1500) quiet = 1;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{left_pixel: lp, right_pixel: rp};
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
        pos_c++;
        if (pos_c >= frame_w) begin
            pos_c = 0;
            pos_r++;
            if (pos_r >= frame_h) pos_r = 0;
        end
    endtask

    // Pixels of the current frame. Modes: 0-2 right image is the left one shifted
    // with slight noise, 3 mostly black, 4-5 unrelated images.
    task automatic send_frame_pixels(int unsigned mode, int count);
        int unsigned shift, src;
        logic [7:0]  lp, rp;
        for (int n = 0; n < frame_w * frame_h; n++) left_img[n] = 8'($urandom);
        shift = $urandom_range(0, 15);
        for (int n = 0; n < count || (count < 0 && (n == 0 || pos_r != 0 || pos_c != 0));
             n++) begin
            src = pos_r * frame_w + pos_c;
            lp  = left_img[src];
            if (mode <= 2) begin
                rp = (pos_c + shift < frame_w) ? left_img[src + shift] : 8'($urandom);
                rp = rp ^ 8'($urandom_range(0, 3));
            end else if (mode == 3) begin
                lp = ($urandom_range(0, 3) == 0) ? lp : 8'h00;
                rp = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
            end else begin
                rp = 8'($urandom);
            end
            send_pixel(lp, rp);
        end
    endtask

    initial begin
        logic [7:0] lp, rp;
        i_rst_n     = 0;
        i_valid     = 0;
        i_data      = '0;
        psel        = 0;
        penable     = 0;
        pwrite      = 0;
        paddr       = '0;
        pwdata      = '0;
        pixels_sent = 0;
        quiet       = 0;
        pos_r       = 0;
        pos_c       = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frame 9x3, window 1: a row of equal full-scale pixels (ties, so
        // the first disparity wins), a row with black left pixels (zero
        // denominators), then a varied row; the small columns give no candidates.
        configure(63, 1, 9, 3);
        for (int n = 0; n < 27; n++) begin
            lp = (n < 9) ? 8'hFF : ((n < 18) ? 8'h00 : 8'(n * 37));
            rp = (n < 9) ? 8'hFF : ((n < 18) ? 8'(n * 53) : 8'(~(n * 37)));
            send_pixel(lp, rp);
        end

        // Largest window and search range, window one short of the narrowest image,
        // a zero window and out-of-range sizes that saturate; the saturated
        // sizes give no results and run only part of a frame.
        configure(63, 8, 30, 10);
        send_frame_pixels(0, -1);
        configure(63, 2, 80, 9);
        send_frame_pixels(1, -1);
        configure(5, 0, 9, 12);
        send_frame_pixels(3, -1);
        configure(0, 8, 9, 9);
        send_frame_pixels(4, -1);
        configure(3, 15, 1023, 0);
        send_frame_pixels(4, 40);
        configure(0, 9, 0, 2047);
        send_frame_pixels(4, 40);

        // Sizes changed part way through a frame: the column and then the row wrap.
        configure(10, 3, 20, 12);
        send_frame_pixels(0, 116);
        configure(7, 3, 12, 5);
        send_frame_pixels(1, -1);

        // Random frames; the last part runs without gaps or stalls.
        while (pixels_sent < 1800) begin
            configure($urandom_range(0, 63),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                  : $urandom_range(1, 8),
                      $urandom_range(9, 40), $urandom_range(9, 14));
            send_frame_pixels($urandom_range(0, 5), -1);
        end

        i_valid <= 1'b0;
        wait_idle();
        if (fail_count == 0) begin
            $display("ncc_stereo_disparity regression: pass");
        end else begin
            $display("ncc_stereo_disparity regression: fail");
        end
        $finish;
    end

endmodule
